@@ rtl/kmh_pkg.sv @@
// Shared types and constants for the k-nearest max-heap store.
// No dependencies; imported by the top level, the checker and the slot RAM users.
`default_nettype none

package kmh_pkg;

    localparam int MAX_K   = 256;
    localparam int ID_BITS = 24;

    localparam int ADDR_W  = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CNT_W   = $clog2(MAX_K + 1);
    localparam int IDX_W   = ADDR_W + 1;

    localparam logic [1:0] OP_START = 2'd0;
    localparam logic [1:0] OP_OFFER = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [23:0] entry_id;
        logic [31:0] dist_key;
        logic [7:0]  read_slot;
    } t_in_word;

    typedef struct packed {
        logic [8:0]  found_count;
        logic [31:0] radius_key;
        logic        store_full;
        logic [23:0] read_entry_id;
        logic [31:0] read_dist_key;
    } t_out_word;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [31:0]        dkey;
    } t_slot;

    localparam int SLOT_W = $bits(t_slot);

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD,
        S_LOAD_W,
        S_SIFT_L,
        S_SIFT_R,
        S_SIFT_C,
        S_ROOT,
        S_ROOT_W,
        S_RD,
        S_RD_W,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

@@ rtl/kmh_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module kmh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                        i_clk,
    input  wire logic                                        i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                            i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                            o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/k_nearest_max_heap.sv @@
// Top level of the k-nearest max-heap store: sequencer, status registers, output word.
// Depends on kmh_pkg and kmh_ram.
`default_nettype none

// Keeps up to K candidates of one nearest-neighbour query in a max-heap held in a
// single slot RAM (one write and one registered read per cycle). A start word, and an
// append that leaves the store short of K, go straight to the output state; a read
// passes a RAM read and its wait state. A full-store offer replaces the root whatever
// its distance; it and each node of the heapify run when the K-th candidate lands go
// through one shared sift-down step per heap level (read left child, read right child,
// compare and move). The heapify covers K/2 nodes, last parent first; a fill of K = 1
// just reads the root back. Input stall stays high for the whole run; the finished
// word sits in an output register so the next word can be taken at once. Distances
// compare as unsigned bit patterns, which orders nonnegative floats.
// The K register is sampled at each start word; write it only while the block is idle.
module k_nearest_max_heap
    import kmh_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [8:0] i_cfg_data
);

    t_state             r_state, n_state;
    logic [8:0]         r_lookup;
    logic [CNT_W-1:0]   r_k, n_k;
    logic [CNT_W-1:0]   r_held, n_held;
    logic [31:0]        r_radius, n_radius;
    t_slot              r_cur, n_cur;
    t_slot              r_left, n_left;
    logic [ADDR_W-1:0]  r_idx, n_idx;
    logic [ADDR_W-1:0]  r_hnode, n_hnode;
    logic [ID_BITS-1:0] r_rd_id, n_rd_id;
    logic [31:0]        r_rd_dist, n_rd_dist;
    t_out_word          r_out, n_out;
    logic               r_out_vld, n_out_vld;

    logic               ram_we;
    logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
    t_slot              ram_wdata, ram_rdata;

    logic [IDX_W-1:0]   lchild, rchild, nn;
    t_slot              cval;
    logic [IDX_W-1:0]   cidx;
    logic               out_free;

    function automatic logic [CNT_W-1:0] eff_k(input logic [8:0] v);
        logic [CNT_W-1:0] k;
        if (v == 9'd0) begin
            k = CNT_W'(1);
        end else if (int'(v) > MAX_K) begin
            k = CNT_W'(MAX_K);
        end else begin
            k = CNT_W'(v);
        end
        return k;
    endfunction

    kmh_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (MAX_K)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign lchild   = {r_idx, 1'b0} | IDX_W'(1);
    assign rchild   = lchild + IDX_W'(1);
    assign nn       = IDX_W'(r_k);
    assign out_free = !r_out_vld || !i_out_stall;

    // larger child, left on a tie
    always_comb begin
        if (rchild < nn && ram_rdata.dkey > r_left.dkey) begin
            cval = ram_rdata;
            cidx = rchild;
        end else begin
            cval = r_left;
            cidx = lchild;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_lookup  <= 9'd1;
            r_k       <= CNT_W'(1);
            r_held    <= '0;
            r_radius  <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_k       <= n_k;
            r_held    <= n_held;
            r_radius  <= n_radius;
            r_out_vld <= n_out_vld;
            if (i_cfg_valid) begin
                r_lookup <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur     <= n_cur;
        r_left    <= n_left;
        r_idx     <= n_idx;
        r_hnode   <= n_hnode;
        r_rd_id   <= n_rd_id;
        r_rd_dist <= n_rd_dist;
        r_out     <= n_out;
    end

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        n_held    = r_held;
        n_radius  = r_radius;
        n_cur     = r_cur;
        n_left    = r_left;
        n_idx     = r_idx;
        n_hnode   = r_hnode;
        n_rd_id   = r_rd_id;
        n_rd_dist = r_rd_dist;
        n_out     = r_out;
        n_out_vld = r_out_vld && i_out_stall;
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = r_cur;
        ram_raddr = '0;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_rd_id   = '0;
                    n_rd_dist = '0;
                    n_state   = S_DONE;
                    unique case (i_in_word.operation)
                        OP_START: begin
                            n_held   = '0;
                            n_radius = i_in_word.dist_key;
                            n_k      = eff_k(r_lookup);
                        end
                        OP_OFFER: begin
                            if (r_held < r_k) begin
                                ram_we    = 1'b1;
                                ram_waddr = ADDR_W'(r_held);
                                ram_wdata = '{id: i_in_word.entry_id[ID_BITS-1:0],
                                              dkey: i_in_word.dist_key};
                                n_held    = r_held + CNT_W'(1);
                                if (n_held == r_k) begin
                                    if ((r_k >> 1) == '0) begin
                                        n_state = S_ROOT;
                                    end else begin
                                        n_hnode = ADDR_W'((r_k >> 1) - CNT_W'(1));
                                        n_state = S_LOAD;
                                    end
                                end
                            end else begin
                                n_cur   = '{id: i_in_word.entry_id[ID_BITS-1:0],
                                            dkey: i_in_word.dist_key};
                                n_idx   = '0;
                                n_hnode = '0;
                                n_state = S_SIFT_L;
                            end
                        end
                        OP_READ: begin
                            if (int'(i_in_word.read_slot) < MAX_K) begin
                                n_idx   = ADDR_W'(i_in_word.read_slot);
                                n_state = S_RD;
                            end
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_LOAD: begin
                ram_raddr = r_hnode;
                n_state   = S_LOAD_W;
            end
            S_LOAD_W: begin
                n_cur   = ram_rdata;
                n_idx   = r_hnode;
                n_state = S_SIFT_L;
            end
            S_SIFT_L: begin
                if (lchild >= nn) begin
                    // leaf reached: drop the held slot here
                    ram_we = 1'b1;
                    if (r_hnode != '0) begin
                        n_hnode = r_hnode - ADDR_W'(1);
                        n_state = S_LOAD;
                    end else begin
                        n_state = S_ROOT;
                    end
                end else begin
                    ram_raddr = ADDR_W'(lchild);
                    n_state   = S_SIFT_R;
                end
            end
            S_SIFT_R: begin
                n_left    = ram_rdata;
                ram_raddr = ADDR_W'(rchild);
                n_state   = S_SIFT_C;
            end
            S_SIFT_C: begin
                ram_we = 1'b1;
                if (cval.dkey > r_cur.dkey) begin
                    ram_wdata = cval;
                    n_idx     = ADDR_W'(cidx);
                    n_state   = S_SIFT_L;
                end else if (r_hnode != '0) begin
                    n_hnode = r_hnode - ADDR_W'(1);
                    n_state = S_LOAD;
                end else begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                ram_raddr = '0;
                n_state   = S_ROOT_W;
            end
            S_ROOT_W: begin
                n_radius = ram_rdata.dkey;
                n_state  = S_DONE;
            end
            S_RD: begin
                ram_raddr = r_idx;
                n_state   = S_RD_W;
            end
            S_RD_W: begin
                n_rd_id   = ram_rdata.id;
                n_rd_dist = ram_rdata.dkey;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    n_out.found_count   = 9'(r_held);
                    n_out.radius_key    = r_radius;
                    n_out.store_full    = (r_held == r_k);
                    n_out.read_entry_id = 24'(r_rd_id);
                    n_out.read_dist_key = r_rd_dist;
                    n_out_vld           = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out;
    assign o_cfg_ready = 1'b1;

endmodule

`default_nettype wire

@@ rtl/kmh_checker.sv @@
// Port-level checks for k_nearest_max_heap, attached by the bind at the end of this file.
// Depends on kmh_pkg.
`default_nettype none

module kmh_checker
    import kmh_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    // a stalled result word stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("result word dropped or changed under stall");

    // the block is still busy in the cycle after every accepted word
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input taken again straight after an accept");

    // a fresh result appears only as the sequencer returns to idle
    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("result word appeared while the sequencer is busy");

    // K is at least one, so a full store is never empty
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_word.store_full && o_out_word.found_count == 9'd0))
        else $error("store reported full with no candidates");

endmodule

bind k_nearest_max_heap kmh_checker u_kmh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);

`default_nettype wire
